### hw/rtl/cbf_pkg.sv
// Shared types, constants and arithmetic helpers of the cubic Bezier flattener.
package cbf_pkg;

   localparam int MaxDepthDef = 7;
   localparam int FracBitsDef = 8;

   localparam int CoordW  = 32;
   localparam int WorkW   = 30;
   localparam int DiffW   = 31;
   localparam int MulW    = 33;
   localparam int ProdW   = 66;
   localparam int CsrIdxW = 4;

   localparam logic [31:0] ScaleReset   = 32'd65536;
   localparam logic [31:0] FlatTolReset = 32'd256;
   localparam logic [2:0]  DepthReset   = 3'd7;

   localparam logic signed [63:0] WorkMax  = 64'sd536870911;
   localparam logic signed [63:0] WorkMin  = -64'sd536870912;
   localparam logic signed [63:0] Int32Max = 64'sd2147483647;
   localparam logic signed [63:0] Int32Min = -64'sd2147483648;

   typedef enum logic [CsrIdxW-1:0] {
      REG_SCALE       = 4'd0,
      REG_FLAT_TOL    = 4'd1,
      REG_DEPTH_LIMIT = 4'd2,
      REG_NEGATE_Y    = 4'd3
   } csr_reg_type;

   // Operations of the shared multiplier
   typedef enum logic [4:0] {
      MOP_NONE, MOP_SOUT, MOP_SWORK,
      MOP_AXDY, MOP_AYDX, MOP_BXDY, MOP_BYDX,
      MOP_DXDX, MOP_DYDY,
      MOP_DLL, MOP_DLH, MOP_DHL, MOP_DHH,
      MOP_TLL, MOP_TLH, MOP_THL, MOP_THH
   } mop_type;

   typedef struct packed {
      logic [31:0] scale;
      logic [31:0] flat_tol;
      logic [2:0]  depth_limit;
      logic        negate_y;
   } cfg_type;

   typedef struct packed {
      logic    take;
      mop_type mop;
      logic [2:0] tag;
      logic    diff;
      logic    init_tree;
      logic    split;
      logic    pop;
      logic    emit;
      logic    flush;
   } cbf_cmd_type;

   typedef struct packed {
      logic in_valid;
      logic is_seg;
      logic line_ok;
      logic not_flat;
      logic pend_valid;
      logic out_free;
      logic stack_empty;
      logic lvl_one;
   } cbf_stat_type;

   // Divide by 2^sh, rounding half away from zero
   function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                     input int sh);
      logic [63:0] m;
      logic [63:0] half;
      if (sh == 0) return v;
      m    = v[63] ? (64'd0 - v) : v;
      half = 64'd1 << (sh - 1);
      m    = (m + half) >> sh;
      return v[63] ? $signed(64'd0 - m) : $signed(m);
   endfunction

   function automatic logic signed [63:0] sat_range(input logic signed [63:0] v,
                                                   input logic signed [63:0] lo,
                                                   input logic signed [63:0] hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic signed [31:0] neg_sat32(input logic signed [31:0] v);
      return (v == 32'sh80000000) ? 32'sh7fffffff : -v;
   endfunction

endpackage

### hw/rtl/cbf_ifs.sv
// Channel interfaces: input item, result item and register write.
interface cbf_req_if import cbf_pkg::*; ();
   logic valid;
   logic ready;
   logic cmd;
   logic signed [CoordW-1:0] c0_x, c0_y, c1_x, c1_y, c2_x, c2_y, c3_x, c3_y;
   modport source(output valid, cmd, c0_x, c0_y, c1_x, c1_y, c2_x, c2_y, c3_x, c3_y,
                  input ready);
   modport sink(input valid, cmd, c0_x, c0_y, c1_x, c1_y, c2_x, c2_y, c3_x, c3_y,
                output ready);
endinterface

interface cbf_rsp_if import cbf_pkg::*; ();
   logic valid;
   logic ready;
   logic signed [CoordW-1:0] out_x, out_y;
   logic last;
   modport source(output valid, out_x, out_y, last, input ready);
   modport sink(input valid, out_x, out_y, last, output ready);
endinterface

interface cbf_csr_if import cbf_pkg::*; ();
   logic valid;
   logic ready;
   logic [CsrIdxW-1:0] index;
   logic [31:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

### hw/rtl/cubic_bezier_flattener.sv
// Top level of the cubic Bezier flattener: registers, sequencer and datapath.
//
//   channel  dir  payload                               transfer when
//   req_ch   in   cmd, c0_x..c3_y                       valid && ready
//   rsp_ch   out  out_x, out_y, last                    valid && ready
//   csr_ch   in   index, data                           valid (ready held high)
//
// A start point, or the end point of a straight segment, is scaled and passed on. A curve has a
// setup and a flush around a walk of its pieces (one flatness test is 14 products through
// the single 33x33 multiplier); a flat piece emits its end point, with up to 127 pieces.
// Synchronous active-high reset clears the sequencer, the walk and the output slot.
// One finished point waits in the output register; a stalled rsp_ch holds the walk
// only when the next point is ready, and the next item is taken while the final
// point still waits.
module cubic_bezier_flattener import cbf_pkg::*; #(
   parameter int MAX_DEPTH = MaxDepthDef,
   parameter int FRAC_BITS = FracBitsDef
) (
   input  logic       clock,
   input  logic       reset,
   cbf_req_if.sink    req_ch,
   cbf_rsp_if.source  rsp_ch,
   cbf_csr_if.sink    csr_ch
);

   cfg_type      cfg;
   cbf_cmd_type  cmd;
   cbf_stat_type stat;

   cbf_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   cbf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   cbf_dpath #(
      .MAX_DEPTH (MAX_DEPTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat),
      .cfg   (cfg),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

endmodule

### hw/rtl/cbf_csr.sv
// Configuration registers of the flattener.
module cbf_csr import cbf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   cbf_csr_if.sink csr,
   output cfg_type cfg
);

   cfg_type cfg_ff;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   // Take a register write on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale       <= ScaleReset;
         cfg_ff.flat_tol    <= FlatTolReset;
         cfg_ff.depth_limit <= DepthReset;
         cfg_ff.negate_y    <= 1'b0;
      end else if (csr.valid) begin
         case (csr.index)
            REG_SCALE:       cfg_ff.scale       <= csr.data;
            REG_FLAT_TOL:    cfg_ff.flat_tol    <= csr.data;
            REG_DEPTH_LIMIT: cfg_ff.depth_limit <= csr.data[2:0];
            REG_NEGATE_Y:    cfg_ff.negate_y    <= csr.data[0];
            default: ;
         endcase
      end
   end

endmodule

### hw/rtl/cbf_ctrl.sv
// Sequencer of the flattener: setup, flatness test, subdivision walk, output.
module cbf_ctrl import cbf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cbf_stat_type stat,
   output cbf_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_LINE, S_SOUT, S_SWORK, S_DRAIN_O, S_DRAIN_W, S_DIFF, S_MUL,
      S_WAIT, S_CMP, S_SPLIT, S_EMIT, S_POP, S_FLUSH
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;

   // Order of products for one flatness test
   function automatic mop_type op_of(input logic [3:0] i);
      case (i)
         4'd0:    return MOP_AXDY;
         4'd1:    return MOP_AYDX;
         4'd2:    return MOP_BXDY;
         4'd3:    return MOP_BYDX;
         4'd4:    return MOP_DXDX;
         4'd5:    return MOP_DYDY;
         4'd6:    return MOP_DLL;
         4'd7:    return MOP_DLH;
         4'd8:    return MOP_DHL;
         4'd9:    return MOP_DHH;
         4'd10:   return MOP_TLL;
         4'd11:   return MOP_TLH;
         4'd12:   return MOP_THL;
         4'd13:   return MOP_THH;
         default: return MOP_NONE;
      endcase
   endfunction

   // Decode commands and next state
   always_comb begin
      cmd      = '0;
      cmd.mop  = MOP_NONE;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            cmd.take = 1'b1;
            if (stat.in_valid) state_in = S_LINE;
         end
         S_LINE: begin
            if (!stat.is_seg) begin
               cnt_in   = 4'd0;
               state_in = S_SOUT;
            end else if (stat.line_ok) begin
               cnt_in   = 4'd6;
               state_in = S_SOUT;
            end else begin
               cnt_in        = 4'd0;
               cmd.init_tree = 1'b1;
               state_in      = S_SWORK;
            end
         end
         S_SOUT: begin
            cmd.mop = MOP_SOUT;
            cmd.tag = cnt_ff[2:0];
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff[0]) state_in = S_DRAIN_O;
         end
         S_SWORK: begin
            cmd.mop = MOP_SWORK;
            cmd.tag = cnt_ff[2:0];
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == 4'd7) state_in = S_DRAIN_W;
         end
         S_DRAIN_O: state_in = S_FLUSH;
         S_DRAIN_W: state_in = S_DIFF;
         S_DIFF: begin
            cmd.diff = 1'b1;
            cnt_in   = 4'd0;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mop = op_of(cnt_ff);
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == 4'd13) state_in = S_WAIT;
         end
         S_WAIT: state_in = S_CMP;
         S_CMP: begin
            if (!stat.not_flat)    state_in = S_EMIT;
            else if (stat.lvl_one) state_in = S_POP;
            else                   state_in = S_SPLIT;
         end
         S_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = S_DIFF;
         end
         S_EMIT: begin
            if (!stat.pend_valid || stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_POP;
            end
         end
         S_POP: begin
            if (stat.stack_empty) begin
               state_in = S_FLUSH;
            end else begin
               cmd.pop  = 1'b1;
               state_in = S_DIFF;
            end
         end
         S_FLUSH: begin
            if (!stat.pend_valid || stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 4'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

### hw/rtl/cbf_dpath.sv
// Datapath: item store, shared multiplier, flatness sums, piece stack, output stage.
module cbf_dpath import cbf_pkg::*; #(
   parameter int MAX_DEPTH = MaxDepthDef,
   parameter int FRAC_BITS = FracBitsDef
) (
   input  logic         clock,
   input  logic         reset,
   input  cbf_cmd_type  cmd,
   output cbf_stat_type stat,
   input  cfg_type      cfg,
   cbf_req_if.sink      req,
   cbf_rsp_if.source    rsp
);

   localparam int StackDepth = (MAX_DEPTH > 1) ? MAX_DEPTH : 2;
   localparam int IdxW       = $clog2(StackDepth);
   localparam int SpW        = IdxW + 1;
   localparam int OutShift   = FRAC_BITS + 16;

   logic                     cmd_item_ff;
   logic signed [CoordW-1:0] item_ff [8];
   logic signed [WorkW-1:0]  cur_ff [8];
   logic signed [WorkW-1:0]  left_pt [8];
   logic signed [WorkW-1:0]  right_pt [8];
   logic signed [WorkW-1:0]  stk_pt_ff [StackDepth][8];
   logic [2:0]               stk_lvl_ff [StackDepth];
   logic [2:0]               lvl_ff, lim;
   logic [SpW-1:0]           sp_ff, sp_dec;
   logic [IdxW-1:0]          pop_idx;

   logic signed [DiffW-1:0]  dx_ff, dy_ff, ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [MulW-1:0]   op_a, op_b;
   logic signed [ProdW-1:0]  prod_ff;
   mop_type                  mop_d_ff;
   logic [2:0]               tag_d_ff;
   logic signed [63:0]       p64, det_tmp, acc_det_ff;
   logic [63:0]              det_abs, dsum_ff, len2_ff, tol_sh;
   logic [127:0]             lhs_ff, rhs_ff, p128;
   logic signed [63:0]       sout_v, swork_v, ex64, ey64;
   logic signed [31:0]       sout_n, ey_n;

   logic                     pend_valid_ff, out_valid_ff, out_last_ff;
   logic signed [31:0]       pend_x_ff, pend_y_ff, out_x_ff, out_y_ff;
   logic                     load;
   logic signed [35:0]       t0, t1, t2, t3;

   function automatic logic signed [WorkW-1:0] half_floor(input logic signed [WorkW-1:0] a,
                                                         input logic signed [WorkW-1:0] b);
      logic signed [WorkW:0] s;
      s = {a[WorkW-1], a} + {b[WorkW-1], b};
      return s[WorkW:1];
   endfunction

   function automatic logic signed [35:0] line_err(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic signed [31:0] c);
      logic signed [35:0] ea, eb, ec;
      ea = 36'(a);
      eb = 36'(b);
      ec = 36'(c);
      return ea + ea + ea - eb - eb - ec;
   endfunction

   function automatic logic near3(input logic signed [35:0] v);
      return (v >= -36'sd3) && (v <= 36'sd3);
   endfunction

   assign load = cmd.take && req.valid;
   assign req.ready = cmd.take;

   // Straight line test on the captured item
   always_comb begin
      t0 = line_err(item_ff[2], item_ff[0], item_ff[6]);
      t1 = line_err(item_ff[4], item_ff[6], item_ff[0]);
      t2 = line_err(item_ff[3], item_ff[1], item_ff[7]);
      t3 = line_err(item_ff[5], item_ff[7], item_ff[1]);
   end

   always_comb begin
      if (cfg.depth_limit == 3'd0)              lim = 3'd1;
      else if (cfg.depth_limit > 3'(MAX_DEPTH)) lim = 3'(MAX_DEPTH);
      else                                      lim = cfg.depth_limit;
   end

   assign sp_dec  = sp_ff - SpW'(1);
   assign pop_idx = sp_dec[IdxW-1:0];

   assign stat.in_valid    = req.valid;
   assign stat.is_seg      = cmd_item_ff;
   assign stat.line_ok     = near3(t0) && near3(t1) && near3(t2) && near3(t3);
   assign stat.not_flat    = lhs_ff >= rhs_ff;
   assign stat.pend_valid  = pend_valid_ff;
   assign stat.out_free    = !out_valid_ff || rsp.ready;
   assign stat.stack_empty = (sp_ff == '0);
   assign stat.lvl_one     = (lvl_ff == 3'd1);

   // Split the current piece at its midpoint
   always_comb begin
      logic signed [WorkW-1:0] m12, m23, m34, m123, m234, mid;
      for (int a = 0; a < 2; a++) begin
         m12  = half_floor(cur_ff[a], cur_ff[2 + a]);
         m23  = half_floor(cur_ff[2 + a], cur_ff[4 + a]);
         m34  = half_floor(cur_ff[4 + a], cur_ff[6 + a]);
         m123 = half_floor(m12, m23);
         m234 = half_floor(m23, m34);
         mid  = half_floor(m123, m234);
         left_pt[a]      = cur_ff[a];
         left_pt[2 + a]  = m12;
         left_pt[4 + a]  = m123;
         left_pt[6 + a]  = mid;
         right_pt[a]     = mid;
         right_pt[2 + a] = m234;
         right_pt[4 + a] = m34;
         right_pt[6 + a] = cur_ff[6 + a];
      end
   end

   assign tol_sh = 64'(cfg.flat_tol) << FRAC_BITS;

   // Select multiplier operands
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cmd.mop)
         MOP_SOUT, MOP_SWORK: begin
            op_a = MulW'(item_ff[cmd.tag]);
            op_b = $signed({1'b0, cfg.scale});
         end
         MOP_AXDY: begin op_a = MulW'(ax_ff); op_b = MulW'(dy_ff); end
         MOP_AYDX: begin op_a = MulW'(ay_ff); op_b = MulW'(dx_ff); end
         MOP_BXDY: begin op_a = MulW'(bx_ff); op_b = MulW'(dy_ff); end
         MOP_BYDX: begin op_a = MulW'(by_ff); op_b = MulW'(dx_ff); end
         MOP_DXDX: begin op_a = MulW'(dx_ff); op_b = MulW'(dx_ff); end
         MOP_DYDY: begin op_a = MulW'(dy_ff); op_b = MulW'(dy_ff); end
         MOP_DLL: begin
            op_a = $signed({1'b0, dsum_ff[31:0]});  op_b = $signed({1'b0, dsum_ff[31:0]});
         end
         MOP_DLH: begin
            op_a = $signed({1'b0, dsum_ff[31:0]});  op_b = $signed({1'b0, dsum_ff[63:32]});
         end
         MOP_DHL: begin
            op_a = $signed({1'b0, dsum_ff[63:32]}); op_b = $signed({1'b0, dsum_ff[31:0]});
         end
         MOP_DHH: begin
            op_a = $signed({1'b0, dsum_ff[63:32]}); op_b = $signed({1'b0, dsum_ff[63:32]});
         end
         MOP_TLL: begin
            op_a = $signed({1'b0, tol_sh[31:0]});   op_b = $signed({1'b0, len2_ff[31:0]});
         end
         MOP_TLH: begin
            op_a = $signed({1'b0, tol_sh[31:0]});   op_b = $signed({1'b0, len2_ff[63:32]});
         end
         MOP_THL: begin
            op_a = $signed({1'b0, tol_sh[63:32]});  op_b = $signed({1'b0, len2_ff[31:0]});
         end
         MOP_THH: begin
            op_a = $signed({1'b0, tol_sh[63:32]});  op_b = $signed({1'b0, len2_ff[63:32]});
         end
         default: ;
      endcase
   end

   // Post-process the registered product
   always_comb begin
      p64     = prod_ff[63:0];
      p128    = {64'd0, prod_ff[63:0]};
      det_tmp = acc_det_ff - p64;
      det_abs = det_tmp[63] ? (64'd0 - det_tmp) : det_tmp;
      sout_v  = sat_range(round_shift(p64, OutShift), Int32Min, Int32Max);
      swork_v = sat_range(round_shift(p64, 16), WorkMin, WorkMax);
      sout_n  = cfg.negate_y ? neg_sat32(sout_v[31:0]) : sout_v[31:0];
      ex64    = round_shift(64'(cur_ff[6]), FRAC_BITS);
      ey64    = round_shift(64'(cur_ff[7]), FRAC_BITS);
      ey_n    = cfg.negate_y ? neg_sat32(ey64[31:0]) : ey64[31:0];
   end

   // Payload registers: item, multiplier, sums, pieces, points
   always_ff @(posedge clock) begin
      if (load) begin
         cmd_item_ff <= req.cmd;
         item_ff[0]  <= req.c0_x;
         item_ff[1]  <= req.c0_y;
         item_ff[2]  <= req.c1_x;
         item_ff[3]  <= req.c1_y;
         item_ff[4]  <= req.c2_x;
         item_ff[5]  <= req.c2_y;
         item_ff[6]  <= req.c3_x;
         item_ff[7]  <= req.c3_y;
      end
      prod_ff  <= op_a * op_b;
      tag_d_ff <= cmd.tag;
      if (cmd.diff) begin
         dx_ff <= DiffW'(cur_ff[6]) - DiffW'(cur_ff[0]);
         dy_ff <= DiffW'(cur_ff[7]) - DiffW'(cur_ff[1]);
         ax_ff <= DiffW'(cur_ff[2]) - DiffW'(cur_ff[6]);
         ay_ff <= DiffW'(cur_ff[3]) - DiffW'(cur_ff[7]);
         bx_ff <= DiffW'(cur_ff[4]) - DiffW'(cur_ff[6]);
         by_ff <= DiffW'(cur_ff[5]) - DiffW'(cur_ff[7]);
      end
      case (mop_d_ff)
         MOP_SOUT: begin
            if (tag_d_ff[0]) pend_y_ff <= sout_n;
            else             pend_x_ff <= sout_v[31:0];
         end
         MOP_SWORK: cur_ff[tag_d_ff] <= swork_v[WorkW-1:0];
         MOP_AXDY, MOP_BXDY: acc_det_ff <= p64;
         MOP_AYDX: dsum_ff <= det_abs;
         MOP_BYDX: dsum_ff <= dsum_ff + det_abs;
         MOP_DXDX: len2_ff <= p64;
         MOP_DYDY: len2_ff <= len2_ff + p64;
         MOP_DLL: lhs_ff <= p128;
         MOP_DLH, MOP_DHL: lhs_ff <= lhs_ff + (p128 << 32);
         MOP_DHH: lhs_ff <= lhs_ff + (p128 << 64);
         MOP_TLL: rhs_ff <= p128;
         MOP_TLH, MOP_THL: rhs_ff <= rhs_ff + (p128 << 32);
         MOP_THH: rhs_ff <= rhs_ff + (p128 << 64);
         default: ;
      endcase
      if (cmd.split) begin
         for (int k = 0; k < 8; k++) begin
            stk_pt_ff[sp_ff[IdxW-1:0]][k] <= right_pt[k];
            cur_ff[k] <= left_pt[k];
         end
         stk_lvl_ff[sp_ff[IdxW-1:0]] <= lvl_ff - 3'd1;
      end else if (cmd.pop) begin
         for (int k = 0; k < 8; k++) cur_ff[k] <= stk_pt_ff[pop_idx][k];
      end
      if (cmd.emit) begin
         pend_x_ff <= ex64[31:0];
         pend_y_ff <= ey_n;
      end
      if ((cmd.emit || cmd.flush) && pend_valid_ff) begin
         out_x_ff    <= pend_x_ff;
         out_y_ff    <= pend_y_ff;
         out_last_ff <= cmd.flush;
      end
   end

   // Control registers: walk position, pending point, output slot
   always_ff @(posedge clock) begin
      if (reset) begin
         mop_d_ff      <= MOP_NONE;
         lvl_ff        <= 3'd1;
         sp_ff         <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         mop_d_ff <= cmd.mop;
         if (cmd.init_tree) begin
            lvl_ff <= lim;
            sp_ff  <= '0;
         end else if (cmd.split) begin
            lvl_ff <= lvl_ff - 3'd1;
            sp_ff  <= sp_ff + SpW'(1);
         end else if (cmd.pop) begin
            lvl_ff <= stk_lvl_ff[pop_idx];
            sp_ff  <= sp_dec;
         end
         if (cmd.emit || (mop_d_ff == MOP_SOUT && tag_d_ff[0])) pend_valid_ff <= 1'b1;
         else if (cmd.flush)                                   pend_valid_ff <= 1'b0;
         if ((cmd.emit || cmd.flush) && pend_valid_ff) out_valid_ff <= 1'b1;
         else if (rsp.ready)                           out_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.out_x = out_x_ff;
   assign rsp.out_y = out_y_ff;
   assign rsp.last  = out_last_ff;

endmodule

### hw/rtl/cbf_checker.sv
// Port-level checks of the flattener and their attachment to the top level.
module cbf_checker import cbf_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [31:0] rsp_x,
   input logic signed [31:0] rsp_y,
   input logic              rsp_last
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_x) && $stable(rsp_y)
                                   && $stable(rsp_last))
      else $error("stalled result changed");

   // Drop the output slot on reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A non-final point means the item is still in progress
   a_busy_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input taken while item unfinished");

   // One item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken straight after a transfer");

endmodule

bind cubic_bezier_flattener cbf_checker u_cbf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_x     (rsp_ch.out_x),
   .rsp_y     (rsp_ch.out_y),
   .rsp_last  (rsp_ch.last)
);

### dv/cbf_tb_ifs.sv
// Testbench constants: point cap per item and watchdog limit.
package cbf_tb_consts;
   localparam int MaxPoints     = 64;
   localparam int WatchdogLimit = 20000;
endpackage

### dv/testbench.sv
// Testbench of the cubic Bezier flattener: directed and random items checked against a predictor.
module testbench import cbf_pkg::*, cbf_tb_consts::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        cmd;
      logic signed [31:0] c [8];
   } bez_item_type;

   typedef struct {
      logic signed [31:0] px, py;
      logic        lastp;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cbf_req_if req_ch ();
   cbf_rsp_if rsp_ch ();
   cbf_csr_if csr_ch ();

   cubic_bezier_flattener u_top (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source),
      .csr_ch(csr_ch.sink)
   );

   always #10 clock = ~clock;

   // Predictor copy of the registers
   logic [31:0] m_scale = ScaleReset;
   logic [31:0] m_tol   = FlatTolReset;
   logic [2:0]  m_depth = DepthReset;
   logic        m_neg   = 1'b0;

   point_type expected_points[$];
   int     fail_count = 0;
   int     idle_cycles = 0;
   int     rsp_gap = 0;
   logic   stim_done = 1'b0;

   // Rounding shift, half away from zero
   function automatic longint rnd_shift(longint v, int sh);
      longint unsigned m;
      m = (v < 0) ? -v : v;
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint floor_half(longint s);
      return (s - (s & 1)) / 2;
   endfunction

   function automatic longint to_int(logic signed [31:0] v);
      return clip(rnd_shift(longint'(v) * longint'({1'b0, m_scale}), 24),
                  -64'sd2147483648, 64'sd2147483647);
   endfunction

   function automatic longint to_work(logic signed [31:0] v);
      return clip(rnd_shift(longint'(v) * longint'({1'b0, m_scale}), 16),
                  -64'sd536870912, 64'sd536870911);
   endfunction

   task automatic push_point(longint x, longint y);
      point_type p;
      if (m_neg) y = (y == -64'sd2147483648) ? 64'sd2147483647 : -y;
      p.px = x[31:0];
      p.py = y[31:0];
      p.lastp = 1'b0;
      expected_points = {expected_points, p};
   endtask

   function automatic bit piece_flat(longint px[4], longint py[4]);
      longint dx, dy, ax, ay, bx, by;
      logic [127:0] d, len2, lhs, rhs;
      dx = px[3] - px[0]; dy = py[3] - py[0];
      ax = px[1] - px[3]; ay = py[1] - py[3];
      bx = px[2] - px[3]; by = py[2] - py[3];
      d = 128'(unsigned'((ax * dy - ay * dx) < 0 ? -(ax * dy - ay * dx)
                                                 : (ax * dy - ay * dx)))
        + 128'(unsigned'((bx * dy - by * dx) < 0 ? -(bx * dy - by * dx)
                                                 : (bx * dy - by * dx)));
      d = 128'(d[63:0]);
      len2 = 128'(unsigned'(dx * dx) + unsigned'(dy * dy));
      lhs = d * d;
      rhs = (128'(m_tol) << 8) * len2;
      return lhs < rhs;
   endfunction

   task automatic subdivide(longint px[4], longint py[4], int lvl, ref int n);
      longint lx[4], ly[4], rx[4], ry[4];
      longint x12, y12, x23, y23, x34, y34;
      if (piece_flat(px, py)) begin
         if (n < MaxPoints) push_point(rnd_shift(px[3], 8), rnd_shift(py[3], 8));
         n++;
         return;
      end
      lvl--;
      if (lvl <= 0) return;
      x12 = floor_half(px[0] + px[1]); y12 = floor_half(py[0] + py[1]);
      x23 = floor_half(px[1] + px[2]); y23 = floor_half(py[1] + py[2]);
      x34 = floor_half(px[2] + px[3]); y34 = floor_half(py[2] + py[3]);
      lx[0] = px[0]; ly[0] = py[0];
      lx[1] = x12; ly[1] = y12;
      lx[2] = floor_half(x12 + x23); ly[2] = floor_half(y12 + y23);
      rx[2] = x34; ry[2] = y34;
      rx[1] = floor_half(x23 + x34); ry[1] = floor_half(y23 + y34);
      rx[3] = px[3]; ry[3] = py[3];
      lx[3] = floor_half(lx[2] + rx[1]); ly[3] = floor_half(ly[2] + ry[1]);
      rx[0] = lx[3]; ry[0] = ly[3];
      subdivide(lx, ly, lvl, n);
      subdivide(rx, ry, lvl, n);
   endtask

   function automatic bit within_lsb(longint v);
      return v >= -3 && v <= 3;
   endfunction

   // Work out the points one item gives and queue them
   task automatic predict_points(bez_item_type it);
      longint c[8];
      longint px[4], py[4];
      int n, before_n, lim;
      for (int i = 0; i < 8; i++) c[i] = longint'(it.c[i]);
      before_n = expected_points.size();
      n = 0;
      if (!it.cmd) begin
         push_point(to_int(it.c[0]), to_int(it.c[1]));
      end else if (within_lsb(3 * c[2] - 2 * c[0] - c[6]) &&
                   within_lsb(3 * c[4] - 2 * c[6] - c[0]) &&
                   within_lsb(3 * c[3] - 2 * c[1] - c[7]) &&
                   within_lsb(3 * c[5] - 2 * c[7] - c[1])) begin
         push_point(to_int(it.c[6]), to_int(it.c[7]));
      end else begin
         for (int i = 0; i < 4; i++) begin
            px[i] = to_work(it.c[2 * i]);
            py[i] = to_work(it.c[2 * i + 1]);
         end
         lim = (m_depth < 1) ? 1 : int'(m_depth);
         subdivide(px, py, lim, n);
      end
      if (expected_points.size() > before_n)
         expected_points[expected_points.size() - 1].lastp = 1'b1;
   endtask

   // Random gap, mostly short, now and then long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic write_reg(csr_reg_type idx, logic [31:0] val);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         REG_SCALE:       m_scale = val;
         REG_FLAT_TOL:    m_tol   = val;
         REG_DEPTH_LIMIT: m_depth = val[2:0];
         REG_NEGATE_Y:    m_neg   = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic send_item(bez_item_type it);
      repeat (gap_len() + 1) @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.cmd   <= it.cmd;
      {req_ch.c0_x, req_ch.c0_y, req_ch.c1_x, req_ch.c1_y} <=
         {it.c[0], it.c[1], it.c[2], it.c[3]};
      {req_ch.c2_x, req_ch.c2_y, req_ch.c3_x, req_ch.c3_y} <=
         {it.c[4], it.c[5], it.c[6], it.c[7]};
      do @(posedge clock); while (!req_ch.ready);
      predict_points(it);
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   // Hold until every expected point has come, then let the walk settle
   task automatic drain();
      while (expected_points.size() != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(0, 20000)) - 10000;
         default: return $signed($urandom_range(0, 2000000)) - 1000000;
      endcase
   endfunction

   function automatic bez_item_type rand_item();
      bez_item_type it;
      int mode;
      longint x0, y0, x3, y3;
      mode = $urandom_range(0, 9);
      it.cmd = ($urandom_range(0, 5) != 0);
      for (int i = 0; i < 8; i++) it.c[i] = rand_coord(mode < 2 ? 0 : (mode < 6 ? 1 : 2));
      // Straight segments with small jitter on the inner points
      if (it.cmd && mode == 9) begin
         x0 = it.c[0]; y0 = it.c[1]; x3 = it.c[6]; y3 = it.c[7];
         it.c[2] = 32'((2 * x0 + x3) / 3 + $signed($urandom_range(0, 2)) - 1);
         it.c[3] = 32'((2 * y0 + y3) / 3);
         it.c[4] = 32'((x0 + 2 * x3) / 3);
         it.c[5] = 32'((y0 + 2 * y3) / 3 + $signed($urandom_range(0, 2)) - 1);
      end
      return it;
   endfunction

   // Directed table: extremes, start points, lines, curves, zero chord
   localparam int DirN = 14;
   bez_item_type dir_tab[DirN];
   point_type    dir_known[DirN];
   bit           dir_has_known[DirN];

   initial begin
      bez_item_type it;
      point_type    got;
      req_ch.valid = 1'b0; req_ch.cmd = 1'b0;
      {req_ch.c0_x, req_ch.c0_y, req_ch.c1_x, req_ch.c1_y} = '0;
      {req_ch.c2_x, req_ch.c2_y, req_ch.c3_x, req_ch.c3_y} = '0;
      csr_ch.valid = 1'b0; csr_ch.index = REG_SCALE; csr_ch.data = '0;

      for (int i = 0; i < DirN; i++) begin
         dir_tab[i].cmd = 1'b1;
         for (int k = 0; k < 8; k++) dir_tab[i].c[k] = '0;
         dir_has_known[i] = 1'b0;
      end
      // Start point at zero, at both extremes and at a small value
      dir_tab[0].cmd = 1'b0;
      dir_known[0] = '{px: 0, py: 0, lastp: 1}; dir_has_known[0] = 1;
      dir_tab[1].cmd = 1'b0; dir_tab[1].c[0] = 32'sh7fffffff; dir_tab[1].c[1] = 32'sh80000000;
      dir_known[1] = '{px: 32'sh00800000, py: 32'shff800000, lastp: 1}; dir_has_known[1] = 1;
      dir_tab[2].cmd = 1'b0; dir_tab[2].c[0] = 32'sd384; dir_tab[2].c[1] = -32'sd384;
      dir_known[2] = '{px: 2, py: -2, lastp: 1}; dir_has_known[2] = 1;
      // Straight line
      dir_tab[3].c = '{0, 0, 768, 0, 1536, 0, 2304, 0};
      dir_known[3] = '{px: 9, py: 0, lastp: 1}; dir_has_known[3] = 1;
      // All points equal is a line too
      dir_tab[4].c = '{256, 256, 256, 256, 256, 256, 256, 256};
      dir_known[4] = '{px: 1, py: 1, lastp: 1}; dir_has_known[4] = 1;
      // Curves of several sizes
      dir_tab[5].c = '{0, 0, 0, 25600, 25600, 25600, 25600, 0};
      dir_tab[6].c = '{-1000000, 0, -1000000, 900000, 1000000, -900000, 1000000, 0};
      dir_tab[7].c = '{0, 0, 2560, 2560, 0, 2560, 0, 0};
      dir_tab[8].c = '{32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                       32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000};
      dir_tab[9].c = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 0, 0, 32'sh7fffffff,
                       32'sh7fffffff, 32'sh7fffffff};
      dir_tab[10].c = '{0, 0, 500, 7000, 9000, -300, 4000, 4000};
      dir_tab[11].c = '{-1, -1, 3, 100, 200, 5, 7, 9};
      dir_tab[12].c = '{10, 20, 30, 0, 0, 40, 50, 60};
      dir_tab[13].c = '{1000, 1000, 1001, 1000, 1000, 1000, 1003, 1000};

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at reset settings
      foreach (dir_tab[i]) begin
         send_item(dir_tab[i]);
         if (dir_has_known[i]) begin
            if (expected_points.size() == 0) begin
               $display("%0t: table row %0d expected x=%0d y=%0d last=%0b got no point",
                        $time, i, dir_known[i].px, dir_known[i].py, dir_known[i].lastp);
               fail_count++;
            end else begin
               got = expected_points[expected_points.size() - 1];
               if (got.px !== dir_known[i].px || got.py !== dir_known[i].py ||
                   got.lastp !== dir_known[i].lastp) begin
                  $display("%0t: table row %0d expected x=%0d y=%0d last=%0b got %0d %0d %0b",
                           $time, i, dir_known[i].px, dir_known[i].py, dir_known[i].lastp,
                           got.px, got.py, got.lastp);
                  fail_count++;
               end
            end
         end
      end
      drain();

      // Random phases across register settings
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: begin write_reg(REG_NEGATE_Y, 1); write_reg(REG_DEPTH_LIMIT, 1); end
            1: begin write_reg(REG_SCALE, 32'hffffffff); write_reg(REG_FLAT_TOL, 0);
                     write_reg(REG_DEPTH_LIMIT, 0); end
            2: begin write_reg(REG_SCALE, 0); write_reg(REG_FLAT_TOL, 32'hffffffff); end
            3: begin write_reg(REG_SCALE, 32'h00008000); write_reg(REG_FLAT_TOL, 16);
                     write_reg(REG_DEPTH_LIMIT, 4); write_reg(REG_NEGATE_Y, 0); end
            4: begin write_reg(REG_SCALE, $urandom);
                     write_reg(REG_FLAT_TOL, $urandom_range(0, 4096));
                     write_reg(REG_DEPTH_LIMIT, $urandom_range(1, 7));
                     write_reg(REG_NEGATE_Y, $urandom_range(0, 1)); end
            5: begin write_reg(REG_SCALE, 32'h00030000); write_reg(REG_FLAT_TOL, 1);
                     write_reg(REG_DEPTH_LIMIT, 7); end
            default: begin write_reg(REG_SCALE, ScaleReset);
                     write_reg(REG_FLAT_TOL, FlatTolReset);
                     write_reg(REG_DEPTH_LIMIT, DepthReset); write_reg(REG_NEGATE_Y, 1); end
         endcase
         for (int j = 0; j < 50; j++) begin
            it = rand_item();
            send_item(it);
         end
         drain();
      end
      stim_done = 1'b1;
   end

   // Result side: ready high for one cycle, then a random gap
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         rsp_gap = gap_len();
      end
   end

   // Check each transfer against the oldest expectation
   always @(posedge clock) begin
      point_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected point x=%0d y=%0d last=%0b", $time,
                     rsp_ch.out_x, rsp_ch.out_y, rsp_ch.last);
            fail_count++;
         end else begin
            e = expected_points.pop_front();
            if (e.px !== rsp_ch.out_x || e.py !== rsp_ch.out_y || e.lastp !== rsp_ch.last) begin
               $display("%0t: point mismatch expected x=%0d y=%0d last=%0b",
                        $time, e.px, e.py, e.lastp);
               $display("%0t: got x=%0d y=%0d last=%0b",
                        $time, rsp_ch.out_x, rsp_ch.out_y, rsp_ch.last);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on transfers, and the end of the run
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchdogLimit) begin
         $display("Verification failed");
         $finish;
      end else if (stim_done) begin
         if (fail_count == 0 && expected_points.size() == 0)
            $display("Verification passed");
         else
            $display("Verification failed");
         $finish;
      end
   end

endmodule
